// ===== src/bsbi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsbi_pkg
// Shared types and constants for the bounded stack with bottom increment.
// ----------------------------------------------------------------------------
package bsbi_pkg;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [1:0]         t_req;

    localparam t_req REQ_PUSH = 2'd0;
    localparam t_req REQ_POP  = 2'd1;
    localparam t_req REQ_INC  = 2'd2;

    localparam logic [0:0] REG_CAPACITY = 1'b0;

    localparam t_field CAPACITY_RESET = 11'd1024;

endpackage

// ===== src/bounded_stack_with_bottom_increment.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_bottom_increment
// Bounded stack of 32-bit words with lazy per-level addends for the
// bottom-increment request; one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  request  | in        | i_in_valid / o_in_stall   | req_type, push_value,
//           |           |                           | inc_count, inc_amount
//  result   | out       | o_out_valid / i_out_stall | pop_value, pop_empty
//  config   | in        | APB psel/penable/pready   | capacity at byte 0
//
//  Push: decode and write. Increment: decode and read, then S_INC1 writes
//  (decode only when nothing is affected). Pop: decode, S_POP1, S_POP2,
//  S_OUT; S_POP2 is skipped when the top is the bottom level and an empty
//  stack goes from decode to S_OUT, where the result waits on i_out_stall.
//  Reset clears occupancy, sequencer and capacity; no clearing pass.
//  o_in_stall is high whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module bounded_stack_with_bottom_increment #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic signed [31:0]            i_push_value,
    input  logic [10:0]                   i_inc_count,
    input  logic signed [31:0]            i_inc_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_pop_value,
    output logic                          o_pop_empty,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsbi_pkg::APB_AW-1:0]   paddr,
    input  logic [bsbi_pkg::APB_DW-1:0]   pwdata,
    output logic [bsbi_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > bsbi_pkg::FIELD_W) ? CW : bsbi_pkg::FIELD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_POP1 = 3'd2;
    localparam logic [2:0] S_POP2 = 3'd3;
    localparam logic [2:0] S_INC1 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            r_state, n_state;
    bsbi_pkg::t_req        r_req;
    bsbi_pkg::t_word       r_val, r_amt;
    bsbi_pkg::t_field      r_cnt;
    bsbi_pkg::t_field      r_capacity;
    logic [CW-1:0]         r_occ, n_occ;
    logic [AW-1:0]         r_addr, n_addr;
    bsbi_pkg::t_word       r_acc, n_acc;
    bsbi_pkg::t_word       r_res, n_res;
    logic                  r_empty, n_empty;
    bsbi_pkg::t_word       r_store_q, r_inc_q;
    logic                  r_out_valid;
    bsbi_pkg::t_word       r_pop_value;
    logic                  r_pop_empty;

    bsbi_pkg::t_word       store_mem [DEPTH];
    bsbi_pkg::t_word       inc_mem   [DEPTH];

    logic                  in_acc, out_free, load_out, room, cfg_we;
    logic                  st_we, inc_we, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    bsbi_pkg::t_word       inc_wdata;
    bsbi_pkg::t_word       add_a, add_b, sum;
    logic [WW-1:0]         k;
    logic [WW-1:0]         k_m1;
    logic [CW-1:0]         occ_m1;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign room   = (WW'(r_occ) < WW'(r_capacity)) && (r_occ < CW'(DEPTH));
    assign k      = (WW'(r_cnt) < WW'(r_occ)) ? WW'(r_cnt) : WW'(r_occ);
    assign k_m1   = k - WW'(1);
    assign occ_m1 = r_occ - CW'(1);
    assign sum    = add_a + add_b;

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_addr    = r_addr;
        n_acc     = r_acc;
        n_res     = r_res;
        n_empty   = r_empty;
        st_we     = 1'b0;
        inc_we    = 1'b0;
        rd_en     = 1'b0;
        wr_addr   = r_addr;
        rd_addr   = r_addr;
        inc_wdata = sum;
        add_a     = r_inc_q;
        add_b     = r_acc;
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                unique case (r_req)
                    bsbi_pkg::REQ_PUSH: begin
                        if (room) begin
                            st_we     = 1'b1;
                            inc_we    = 1'b1;
                            wr_addr   = r_occ[AW-1:0];
                            inc_wdata = '0;
                            n_occ     = r_occ + CW'(1);
                        end
                    end
                    bsbi_pkg::REQ_POP: begin
                        if (r_occ == '0) begin
                            n_res   = '0;
                            n_empty = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_occ   = occ_m1;
                            n_addr  = occ_m1[AW-1:0];
                            rd_en   = 1'b1;
                            rd_addr = occ_m1[AW-1:0];
                            n_state = S_POP1;
                        end
                    end
                    bsbi_pkg::REQ_INC: begin
                        if (k != '0) begin
                            n_addr  = k_m1[AW-1:0];
                            rd_en   = 1'b1;
                            rd_addr = k_m1[AW-1:0];
                            n_state = S_INC1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_POP1: begin
                add_a   = r_store_q;
                add_b   = r_inc_q;
                n_res   = sum;
                n_empty = 1'b0;
                n_acc   = r_inc_q;
                if (r_addr != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr - AW'(1);
                    n_addr  = r_addr - AW'(1);
                    n_state = S_POP2;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_POP2: begin
                add_a   = r_inc_q;
                add_b   = r_acc;
                inc_we  = 1'b1;
                n_state = S_OUT;
            end
            S_INC1: begin
                add_a   = r_inc_q;
                add_b   = r_amt;
                inc_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_req_type;
            r_val <= i_push_value;
            r_cnt <= i_inc_count;
            r_amt <= i_inc_amount;
        end
        r_addr  <= n_addr;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_empty <= n_empty;
        if (load_out) begin
            r_pop_value <= r_res;
            r_pop_empty <= r_empty;
        end
    end

    // entry store and per-level addend store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            store_mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_store_q <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (inc_we) begin
            inc_mem[wr_addr] <= inc_wdata;
        end
        if (rd_en) begin
            r_inc_q <= inc_mem[rd_addr];
        end
    end

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == bsbi_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == bsbi_pkg::REG_CAPACITY) ?
                    bsbi_pkg::APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bsbi_pkg::CAPACITY_RESET;
        end else if (cfg_we) begin
            r_capacity <= pwdata[bsbi_pkg::FIELD_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_pop_empty = r_pop_empty;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DEC))
        else $error("accepted transfer not decoded");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_req == bsbi_pkg::REQ_PUSH && room)
        |=> (r_occ == $past(r_occ) + CW'(1)))
        else $error("push with room did not grow the stack");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_req == bsbi_pkg::REQ_POP && r_occ == '0)
        |=> (r_state == S_OUT && r_empty && r_res == '0))
        else $error("empty pop not flagged");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_out_valid)
        else $error("pop result not presented");

endmodule

// ===== tb/sv/bsbi_checker.sv =====
// ----------------------------------------------------------------------------
// bsbi_checker
// Watches the request, result and APB ports of the bounded stack, keeps its
// own copy of the stack and capacity, and compares every popped result and
// every register read against that copy. Sampling is on the falling edge,
// where all ports are settled for the transfer at the next rising edge.
// ----------------------------------------------------------------------------
module bsbi_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic signed [31:0]            i_push_value,
    input  logic [10:0]                   i_inc_count,
    input  logic signed [31:0]            i_inc_amount,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [31:0]            o_pop_value,
    input  logic                          o_pop_empty,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsbi_pkg::APB_AW-1:0]   paddr,
    input  logic [bsbi_pkg::APB_DW-1:0]   pwdata,
    input  logic [bsbi_pkg::APB_DW-1:0]   prdata,
    input  logic                          pready,
    output int                            n_fail,
    output int                            n_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bsbi_pkg::APB_AW-1:0] CAPACITY_ADDR =
        bsbi_pkg::APB_AW'(4 * bsbi_pkg::REG_CAPACITY);

    typedef struct packed {
        bsbi_pkg::t_word value;
        logic            empty;
    } t_pop_result;

    t_pop_result       pop_results[$];
    bsbi_pkg::t_word   level_word[DEPTH];
    int unsigned       level_count = 0;
    bsbi_pkg::t_field  capacity    = bsbi_pkg::CAPACITY_RESET;
    int                fail_total  = 0;
    int                waiting_total = 0;

    assign n_fail    = fail_total;
    assign n_waiting = waiting_total;

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
        fail_total++;
    endtask

    task apply_request(bsbi_pkg::t_req req, bsbi_pkg::t_word push_value,
                       bsbi_pkg::t_field inc_count, bsbi_pkg::t_word inc_amount);
        int unsigned limit;
        int unsigned reach;
        t_pop_result pend;
        limit = (capacity > DEPTH) ? DEPTH : capacity;
        case (req)
            bsbi_pkg::REQ_PUSH: begin
                if (level_count < limit) begin
                    level_word[level_count] = push_value;
                    level_count++;
                end
            end
            bsbi_pkg::REQ_POP: begin
                if (level_count == 0) begin
                    pend.value = '0;
                    pend.empty = 1'b1;
                end else begin
                    level_count--;
                    pend.value = level_word[level_count];
                    pend.empty = 1'b0;
                end
                pop_results.insert(pop_results.size(), pend);
            end
            bsbi_pkg::REQ_INC: begin
                reach = (inc_count < level_count) ? inc_count : level_count;
                for (int k = 0; k < reach; k++) begin
                    level_word[k] = level_word[k] + inc_amount;
                end
            end
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        t_pop_result want;
        if (!i_rst_n) begin
            level_count = 0;
            capacity = bsbi_pkg::CAPACITY_RESET;
            pop_results.delete();
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pop_results.size() == 0) begin
                    report_mismatch("result with none pending", o_pop_value, '0);
                end else begin
                    want = pop_results.pop_front();
                    if (o_pop_empty !== want.empty)
                        report_mismatch("pop_empty", 32'(o_pop_empty), 32'(want.empty));
                    if (o_pop_value !== want.value)
                        report_mismatch("pop_value", o_pop_value, want.value);
                end
            end
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0)
                apply_request(i_req_type, i_push_value, i_inc_count, i_inc_amount);
            if (psel && penable && pready === 1'b1 && paddr == CAPACITY_ADDR) begin
                if (pwrite) begin
                    capacity = pwdata[bsbi_pkg::FIELD_W-1:0];
                end else if (prdata !== bsbi_pkg::APB_DW'(capacity)) begin
                    report_mismatch("capacity read", prdata,
                                    bsbi_pkg::APB_DW'(capacity));
                end
            end
        end
        waiting_total = pop_results.size();
    end

endmodule

// ===== tb/sv/bounded_stack_with_bottom_increment_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_bottom_increment_tb
// Drives push, pop, increment and unused requests into the bounded stack
// under several capacity settings, with random gaps on the request side and
// random stalls on the result side, including one long result hold-off that
// backs the block up. Results are checked by bsbi_checker.
// ----------------------------------------------------------------------------
module bounded_stack_with_bottom_increment_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   DEPTH         = 1024;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   HOLD_CYCLES   = 300;
    localparam bsbi_pkg::t_req REQ_UNUSED = 2'd3;
    localparam logic [bsbi_pkg::APB_AW-1:0] CAPACITY_ADDR =
        bsbi_pkg::APB_AW'(4 * bsbi_pkg::REG_CAPACITY);

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type   = '0;
    logic signed [31:0] i_push_value = '0;
    logic [10:0]        i_inc_count  = '0;
    logic signed [31:0] i_inc_amount = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic signed [31:0] o_pop_value;
    logic               o_pop_empty;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [bsbi_pkg::APB_AW-1:0] paddr  = '0;
    logic [bsbi_pkg::APB_DW-1:0] pwdata = '0;
    logic [bsbi_pkg::APB_DW-1:0] prdata;
    logic               pready;
    int                 n_fail;
    int                 n_waiting;

    bit sender_idles = 1'b1;
    bit hold_wanted  = 1'b0;

    bounded_stack_with_bottom_increment #(.DEPTH(DEPTH)) i_dut (.*);

    bsbi_checker #(.DEPTH(DEPTH)) i_checker (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, free-flowing stretches, one long hold-off
    initial begin : out_stall_driver
        int  run;
        bit  level;
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                case ($urandom_range(0, 9)) inside
                    [0:3]:   begin level = 1'b0; run = $urandom_range(1, 6);   end
                    [4:5]:   begin level = 1'b0; run = $urandom_range(20, 60); end
                    [6:8]:   begin level = 1'b1; run = $urandom_range(1, 3);   end
                    default: begin level = 1'b1; run = $urandom_range(8, 40);  end
                endcase
                repeat (run) begin
                    @(posedge i_clk);
                    i_out_stall <= level;
                end
            end
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idles || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    function automatic bsbi_pkg::t_word random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 3);
            3:       return 32'hffff_ffff - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic bsbi_pkg::t_field random_count();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return bsbi_pkg::t_field'($urandom_range(0, 8));
            [4:6]:   return bsbi_pkg::t_field'($urandom_range(0, 64));
            7:       return 11'h7ff;
            default: return bsbi_pkg::t_field'($urandom_range(0, 2047));
        endcase
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task send_request(bsbi_pkg::t_req req, bsbi_pkg::t_word push_value,
                      bsbi_pkg::t_field inc_count, bsbi_pkg::t_word inc_amount);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_push_value <= push_value;
        i_inc_count  <= inc_count;
        i_inc_amount <= inc_amount;
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        @(posedge i_clk);
    endtask

    task push_word(bsbi_pkg::t_word value);
        send_request(bsbi_pkg::REQ_PUSH, value, random_count(), random_word());
    endtask

    task pop_word();
        send_request(bsbi_pkg::REQ_POP, random_word(), random_count(), random_word());
    endtask

    task inc_bottom(bsbi_pkg::t_field count, bsbi_pkg::t_word amount);
        send_request(bsbi_pkg::REQ_INC, random_word(), count, amount);
    endtask

    task drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (n_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task apb_access(bit is_write, bsbi_pkg::t_field value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= bsbi_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (pready !== 1'b1);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task set_capacity(bsbi_pkg::t_field value);
        drain();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    task run_mix(int n, int push_pct, int pop_pct, int inc_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                push_word(random_word());
            else if (r < push_pct + pop_pct)
                pop_word();
            else if (r < push_pct + pop_pct + inc_pct)
                inc_bottom(random_count(), random_word());
            else
                send_request(REQ_UNUSED, random_word(), random_count(), random_word());
        end
    endtask

    task fill_stack(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 37 == 36)
                inc_bottom(bsbi_pkg::t_field'($urandom_range(0, 2047)), random_word());
            else
                push_word(random_word());
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, '0);

        // directed: empty pop, word extremes, wrapping, clamping, unused code
        pop_word();
        push_word(32'h7fff_ffff);
        push_word(32'h8000_0000);
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        inc_bottom(11'd0, 32'd5);
        inc_bottom(11'h7ff, 32'd1);
        inc_bottom(11'd2, 32'h8000_0000);
        send_request(REQ_UNUSED, random_word(), random_count(), random_word());
        inc_bottom(11'd1, 32'h7fff_ffff);
        repeat (5) pop_word();
        inc_bottom(11'd5, 32'd7);

        set_capacity(11'd0);
        push_word(32'h0000_0055);
        pop_word();

        set_capacity(11'd2);
        push_word(32'h0000_0001);
        push_word(32'h0000_0002);
        push_word(32'h0000_0003);
        set_capacity(11'd1);
        push_word(32'h0000_0004);
        pop_word();
        pop_word();

        // random phases over several capacities
        sender_idles = 1'b1;
        set_capacity(11'd1);
        run_mix(150, 40, 40, 15);

        set_capacity(11'd0);
        run_mix(60, 40, 40, 15);

        set_capacity(11'd3);
        run_mix(150, 45, 35, 15);

        sender_idles = 1'b0;
        set_capacity(11'd17);
        run_mix(150, 50, 30, 15);

        sender_idles = 1'b1;
        set_capacity(11'h7ff);
        fill_stack(1070);
        hold_wanted = 1'b1;
        run_mix(130, 15, 70, 10);

        set_capacity(11'd2);
        run_mix(130, 40, 45, 10);

        set_capacity(bsbi_pkg::t_field'($urandom_range(1, 1024)));
        run_mix(80, 45, 40, 10);

        drain();
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
